// ===== design/hrmp_pkg.sv =====
// shared types and constants for the heart rate measurement parser
// no dependencies

package hrmp_pkg;

  // flags byte bits
  localparam logic [7:0] FLAG_RATE16  = 8'h01;
  localparam logic [7:0] FLAG_CONTACT = 8'h02;
  localparam logic [7:0] FLAG_SUPPORT = 8'h04;
  localparam logic [7:0] FLAG_ENERGY  = 8'h08;
  localparam logic [7:0] FLAG_RR      = 8'h10;

  localparam logic [7:0] RATE_SAT   = 8'd255;
  localparam logic [7:0] INDEX_LAST = 8'd255;

  localparam logic [1:0] CONTACT_NONE  = 2'd0;
  localparam logic [1:0] CONTACT_YES   = 2'd1;
  localparam logic [1:0] CONTACT_UNREP = 2'd2;

  localparam logic KIND_RR      = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int RR_CNT_W = 4;

  typedef struct packed {
    logic                kind;
    logic [15:0]         rr_interval;
    logic [7:0]          bpm;
    logic [1:0]          contact;
    logic                has_energy;
    logic [15:0]         energy_kj;
    logic [RR_CNT_W-1:0] rr_total;
    logic [31:0]         packets_seen;
    logic                end_of_packet;
  } hrmp_result_t;

  // which results one word produces
  typedef struct packed {
    logic rr;
    logic sum;
  } hrmp_emit_t;

endpackage

// ===== design/heart_rate_measurement_parser_core.sv =====
// heart rate measurement parser: input register, decode and a four-entry result queue
// depends on hrmp_pkg and hrmp_parse
//
//   port group   direction   payload
//   in_*         in          data_byte, last_byte, is_hr_char
//   out_*        out         kind, rr_interval, bpm, contact, has_energy, energy_kj,
//                            rr_total, packets_seen, end_of_packet
//
// one word per cycle unless in_stall is high; a word is registered, decoded, then queued
// a word gives at most two results (rr interval and summary on the last word);
// the decode stage waits while the queue has fewer than two free entries
// out_stall only holds the queue; in_stall follows from the queue fill level
// synchronous active-low reset clears the packet state, counter and queue

module heart_rate_measurement_parser_core #(
  parameter int MAX_RR = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_is_hr_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_rr_interval,
  output logic [7:0]  out_bpm,
  output logic [1:0]  out_contact,
  output logic        out_has_energy,
  output logic [15:0] out_energy_kj,
  output logic [3:0]  out_rr_total,
  output logic [31:0] out_packets_seen,
  output logic        out_end_of_packet
);
  import hrmp_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_hr_r;
  logic       s1_go;
  logic       fire;

  hrmp_result_t rr_res, sum_res, res_a;
  hrmp_emit_t   emit;

  hrmp_result_t      q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic [1:0]        push_n;
  logic              pop;

  // room for two results before the decode stage moves
  assign s1_go    = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign fire     = s1_valid_r & s1_go;
  assign in_stall = s1_valid_r & ~s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_hr_r   <= in_is_hr_char;
    end
  end

  hrmp_parse #(
    .MAX_RR(MAX_RR)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .is_hr_char(s1_hr_r),
    .rr_res    (rr_res),
    .sum_res   (sum_res),
    .emit      (emit)
  );

  assign res_a   = emit.rr ? rr_res : sum_res;
  assign push_n  = {1'b0, emit.rr} + {1'b0, emit.sum};
  assign pop     = out_valid & ~out_stall;
  assign cnt_nxt = cnt_r + {{(QPTR_W-1){1'b0}}, push_n} - {{QPTR_W{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // rr result goes first when a last word also closes the packet
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= res_a;
    if (push_n == 2'd2) q_r[wr_ptr_r + QPTR_W'(1)] <= sum_res;
  end

  assign out_valid         = (cnt_r != '0);
  assign out_kind          = q_r[rd_ptr_r].kind;
  assign out_rr_interval   = q_r[rd_ptr_r].rr_interval;
  assign out_bpm           = q_r[rd_ptr_r].bpm;
  assign out_contact       = q_r[rd_ptr_r].contact;
  assign out_has_energy    = q_r[rd_ptr_r].has_energy;
  assign out_energy_kj     = q_r[rd_ptr_r].energy_kj;
  assign out_rr_total      = q_r[rd_ptr_r].rr_total;
  assign out_packets_seen  = q_r[rd_ptr_r].packets_seen;
  assign out_end_of_packet = q_r[rd_ptr_r].end_of_packet;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r == $past(cnt_nxt))
    else $error("queue count lost track");

  a_kind_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_SUMMARY) == out_end_of_packet)
    else $error("summary kind and end of packet disagree");

  a_summary_rr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_rr_interval == 16'd0)
    else $error("summary carries an rr interval");

  a_no_push_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> push_n == 2'd0)
    else $error("results pushed without a decode step");

endmodule

// ===== design/hrmp_parse.sv =====
// per-packet decode state and the one-word update of the parser
// depends on hrmp_pkg

module hrmp_parse #(
  parameter int MAX_RR = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 is_hr_char,
  output hrmp_pkg::hrmp_result_t rr_res,
  output hrmp_pkg::hrmp_result_t sum_res,
  output hrmp_pkg::hrmp_emit_t   emit
);
  import hrmp_pkg::*;

  logic [7:0]          byte_index_r, byte_index_nxt;
  logic [7:0]          flag_bits_r, flag_bits_nxt;
  logic [7:0]          low_byte_hold_r, low_byte_hold_nxt;
  logic [7:0]          rate_value_r, rate_value_nxt;
  logic [15:0]         energy_value_r, energy_value_nxt;
  logic                energy_seen_r, energy_seen_nxt;
  logic [RR_CNT_W-1:0] rr_seen_r, rr_seen_nxt;
  logic                packet_bad_r, packet_bad_nxt;
  logic [31:0]         notify_count_r, notify_count_nxt;

  logic [7:0]  flags;
  logic        bad;
  logic        wide;
  logic        has_en;
  logic [7:0]  e_start;
  logic [7:0]  rr_start;
  logic [7:0]  rr_off;
  logic        active;
  logic        rr_fire;
  logic        sum_ok;
  logic [31:0] count_next;
  logic [1:0]  contact;
  logic [7:0]  rate_cur;
  logic [15:0] energy_cur;
  logic        energy_seen_cur;
  hrmp_result_t common;

  always_comb begin
    byte_index_nxt    = byte_index_r;
    flag_bits_nxt     = flag_bits_r;
    low_byte_hold_nxt = low_byte_hold_r;
    rate_value_nxt    = rate_value_r;
    energy_value_nxt  = energy_value_r;
    energy_seen_nxt   = energy_seen_r;
    rr_seen_nxt       = rr_seen_r;
    packet_bad_nxt    = packet_bad_r;
    notify_count_nxt  = notify_count_r;
    rr_fire           = 1'b0;

    bad      = packet_bad_r | ~is_hr_char;
    flags    = (byte_index_r == 8'd0) ? data_byte : flag_bits_r;
    wide     = |(flags & FLAG_RATE16);
    has_en   = |(flags & FLAG_ENERGY);
    e_start  = wide ? 8'd3 : 8'd2;
    rr_start = e_start + (has_en ? 8'd2 : 8'd0);
    rr_off   = byte_index_r - rr_start;
    active   = ~bad && (byte_index_r != 8'd0) && (byte_index_r != INDEX_LAST);

    flag_bits_nxt  = flags;
    packet_bad_nxt = bad;

    if (active) begin
      priority if (byte_index_r == 8'd1) begin
        if (wide) low_byte_hold_nxt = data_byte;
        else rate_value_nxt = data_byte;
      end else if (byte_index_r == 8'd2 && wide) begin
        // 16-bit rate saturates to one byte
        rate_value_nxt = (data_byte != 8'd0) ? RATE_SAT : low_byte_hold_r;
      end else if (has_en && byte_index_r == e_start) begin
        low_byte_hold_nxt = data_byte;
      end else if (has_en && byte_index_r == e_start + 8'd1) begin
        energy_value_nxt = {data_byte, low_byte_hold_r};
        energy_seen_nxt  = 1'b1;
      end else if (|(flags & FLAG_RR) && byte_index_r >= rr_start) begin
        if (!rr_off[0]) begin
          low_byte_hold_nxt = data_byte;
        end else if (rr_seen_r < RR_CNT_W'(MAX_RR) && rr_off[7:1] < 7'(MAX_RR)) begin
          rr_seen_nxt = rr_seen_r + RR_CNT_W'(1);
          rr_fire     = 1'b1;
        end
      end
    end

    // packet values after this word, before the end-of-packet clear
    rate_cur        = rate_value_nxt;
    energy_cur      = energy_value_nxt;
    energy_seen_cur = energy_seen_nxt;

    if (byte_index_r != INDEX_LAST) byte_index_nxt = byte_index_r + 8'd1;

    sum_ok     = last_byte && ~bad && (byte_index_r >= 8'd1) &&
                 (~wide || byte_index_r >= 8'd2);
    count_next = notify_count_r + 32'd1;

    if (last_byte) begin
      if (sum_ok) notify_count_nxt = count_next;
      byte_index_nxt    = 8'd0;
      flag_bits_nxt     = 8'd0;
      low_byte_hold_nxt = 8'd0;
      rate_value_nxt    = 8'd0;
      energy_value_nxt  = 16'd0;
      energy_seen_nxt   = 1'b0;
      rr_seen_nxt       = '0;
      packet_bad_nxt    = 1'b0;
    end
  end

  // results see the state as updated by this word
  always_comb begin
    if (!(|(flags & FLAG_SUPPORT))) contact = CONTACT_UNREP;
    else if (|(flags & FLAG_CONTACT)) contact = CONTACT_YES;
    else contact = CONTACT_NONE;

    common.kind          = KIND_RR;
    common.rr_interval   = 16'd0;
    common.bpm           = rate_cur;
    common.contact       = contact;
    common.has_energy    = energy_seen_cur;
    common.energy_kj     = energy_seen_cur ? energy_cur : 16'd0;
    common.rr_total      = rr_fire ? rr_seen_r + RR_CNT_W'(1) : rr_seen_r;
    common.packets_seen  = count_next;
    common.end_of_packet = 1'b0;

    rr_res             = common;
    rr_res.rr_interval = {data_byte, low_byte_hold_r};

    sum_res               = common;
    sum_res.kind          = KIND_SUMMARY;
    sum_res.end_of_packet = 1'b1;
  end

  assign emit.rr  = step & rr_fire;
  assign emit.sum = step & sum_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r    <= 8'd0;
      flag_bits_r     <= 8'd0;
      low_byte_hold_r <= 8'd0;
      rate_value_r    <= 8'd0;
      energy_value_r  <= 16'd0;
      energy_seen_r   <= 1'b0;
      rr_seen_r       <= '0;
      packet_bad_r    <= 1'b0;
      notify_count_r  <= 32'd0;
    end else if (step) begin
      byte_index_r    <= byte_index_nxt;
      flag_bits_r     <= flag_bits_nxt;
      low_byte_hold_r <= low_byte_hold_nxt;
      rate_value_r    <= rate_value_nxt;
      energy_value_r  <= energy_value_nxt;
      energy_seen_r   <= energy_seen_nxt;
      rr_seen_r       <= rr_seen_nxt;
      packet_bad_r    <= packet_bad_nxt;
      notify_count_r  <= notify_count_nxt;
    end
  end

endmodule

// ===== tb/hrmp_result_checker.sv =====
// result checker for the heart rate measurement parser: tracks the packet decode per
// accepted word, keeps the expected results in order and compares every result taken
// depends on hrmp_pkg

module hrmp_result_checker #(
  parameter int MAX_RR = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_is_hr_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [15:0] out_rr_interval,
  input  logic [7:0]  out_bpm,
  input  logic [1:0]  out_contact,
  input  logic        out_has_energy,
  input  logic [15:0] out_energy_kj,
  input  logic [3:0]  out_rr_total,
  input  logic [31:0] out_packets_seen,
  input  logic        out_end_of_packet,
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrmp_pkg::*;

  // decode state of the packet in flight
  logic [7:0]  byte_pos;
  logic [7:0]  flags;
  logic [7:0]  low_hold;
  logic [7:0]  rate;
  logic [15:0] energy;
  logic        energy_ok;
  logic [3:0]  rr_count;
  logic        dropped;
  logic [31:0] packet_count;

  hrmp_result_t expected_results[$];
  int fail_total;

  initial begin
    fail_total = 0;
  end

  task automatic clear_packet();
    byte_pos = '0;
    flags = '0;
    low_hold = '0;
    rate = '0;
    energy = '0;
    energy_ok = 1'b0;
    rr_count = '0;
    dropped = 1'b0;
  endtask

  function automatic hrmp_result_t make_result(logic kind, logic [15:0] rr,
                                               logic [31:0] count, logic eop);
    hrmp_result_t r;
    r.kind = kind;
    r.rr_interval = rr;
    r.bpm = rate;
    if ((flags & FLAG_SUPPORT) == 8'd0) r.contact = CONTACT_UNREP;
    else r.contact = ((flags & FLAG_CONTACT) != 8'd0) ? CONTACT_YES : CONTACT_NONE;
    r.has_energy = energy_ok;
    r.energy_kj = energy_ok ? energy : 16'd0;
    r.rr_total = rr_count;
    r.packets_seen = count;
    r.end_of_packet = eop;
    return r;
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic last, input logic hr);
    int idx;
    int e_start;
    int rr_start;
    int off;
    logic wide;
    logic [15:0] v;
    idx = int'(byte_pos);
    if (!hr) dropped = 1'b1;
    if (idx == 0) flags = b;
    wide = (flags & FLAG_RATE16) != 8'd0;
    e_start = wide ? 3 : 2;
    rr_start = e_start + (((flags & FLAG_ENERGY) != 8'd0) ? 2 : 0);
    if (!dropped && idx != 0 && idx < INDEX_LAST) begin
      if (idx == 1) begin
        if (wide) low_hold = b;
        else rate = b;
      end else if (idx == 2 && wide) begin
        v = {b, low_hold};
        rate = (v > 16'd255) ? RATE_SAT : v[7:0];
      end else if ((flags & FLAG_ENERGY) != 8'd0 && idx == e_start) begin
        low_hold = b;
      end else if ((flags & FLAG_ENERGY) != 8'd0 && idx == e_start + 1) begin
        energy = {b, low_hold};
        energy_ok = 1'b1;
      end else if ((flags & FLAG_RR) != 8'd0 && idx >= rr_start) begin
        off = idx - rr_start;
        if (off % 2 == 0) begin
          low_hold = b;
        end else if (rr_count < MAX_RR && (off / 2) < MAX_RR) begin
          rr_count = rr_count + 4'd1;
          expected_results.push_back(make_result(KIND_RR, {b, low_hold},
                                                 packet_count + 32'd1, 1'b0));
        end
      end
    end
    if (byte_pos != INDEX_LAST) byte_pos = byte_pos + 8'd1;
    if (last) begin
      // too short: just the flags, or a 16-bit rate missing its high byte
      if (!dropped && idx >= 1 && (!wide || idx >= 2)) begin
        packet_count = packet_count + 32'd1;
        expected_results.push_back(make_result(KIND_SUMMARY, 16'd0, packet_count, 1'b1));
      end
      clear_packet();
    end
  endtask

  task automatic report(input string what, input hrmp_result_t want, input hrmp_result_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%s at %0t", what, $realtime);
      $display("  exp kind=%0d rr=%h bpm=%0d ct=%0d en=%0d/%h rrn=%0d pk=%0d eop=%0d",
               want.kind, want.rr_interval, want.bpm, want.contact, want.has_energy,
               want.energy_kj, want.rr_total, want.packets_seen, want.end_of_packet);
      $display("  got kind=%0d rr=%h bpm=%0d ct=%0d en=%0d/%h rrn=%0d pk=%0d eop=%0d",
               got.kind, got.rr_interval, got.bpm, got.contact, got.has_energy,
               got.energy_kj, got.rr_total, got.packets_seen, got.end_of_packet);
    end
  endtask

  task automatic check_result();
    hrmp_result_t got;
    hrmp_result_t want;
    got = {out_kind, out_rr_interval, out_bpm, out_contact, out_has_energy,
           out_energy_kj, out_rr_total, out_packets_seen, out_end_of_packet};
    if (expected_results.size() == 0) begin
      report("unexpected result", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.rr_interval !== want.rr_interval ||
          got.bpm !== want.bpm || got.contact !== want.contact ||
          got.has_energy !== want.has_energy || got.energy_kj !== want.energy_kj ||
          got.rr_total !== want.rr_total || got.packets_seen !== want.packets_seen ||
          got.end_of_packet !== want.end_of_packet)
        report("result mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_packet();
      packet_count = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) decode_word(in_data_byte, in_last_byte, in_is_hr_char);
    end
    results_due <= expected_results.size();
    mismatches <= fail_total;
  end

endmodule

// ===== tb/heart_rate_measurement_parser_core_tb.sv =====
// testbench top for heart_rate_measurement_parser_core: drives notification words,
// varies idle and stall pressure, and gives the verdict from hrmp_result_checker
// depends on hrmp_pkg, hrmp_result_checker and the parser core

module heart_rate_measurement_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrmp_pkg::*;

  localparam int MAX_RR       = 9;
  localparam int RANDOM_ITEMS = 160;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        in_is_hr_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [15:0] out_rr_interval;
  logic [7:0]  out_bpm;
  logic [1:0]  out_contact;
  logic        out_has_energy;
  logic [15:0] out_energy_kj;
  logic [3:0]  out_rr_total;
  logic [31:0] out_packets_seen;
  logic        out_end_of_packet;

  int mismatches;
  int results_due;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int quiet = 0;
  int words_sent = 0;

  logic [7:0] frame[$];
  int foreign_at;

  always #6 clk = ~clk;

  heart_rate_measurement_parser_core #(.MAX_RR(MAX_RR)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .in_is_hr_char(in_is_hr_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_rr_interval(out_rr_interval), .out_bpm(out_bpm),
    .out_contact(out_contact), .out_has_energy(out_has_energy),
    .out_energy_kj(out_energy_kj), .out_rr_total(out_rr_total),
    .out_packets_seen(out_packets_seen), .out_end_of_packet(out_end_of_packet)
  );

  hrmp_result_checker #(.MAX_RR(MAX_RR)) result_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .in_is_hr_char(in_is_hr_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_rr_interval(out_rr_interval), .out_bpm(out_bpm),
    .out_contact(out_contact), .out_has_energy(out_has_energy),
    .out_energy_kj(out_energy_kj), .out_rr_total(out_rr_total),
    .out_packets_seen(out_packets_seen), .out_end_of_packet(out_end_of_packet),
    .mismatches(mismatches), .results_due(results_due)
  );

  // receiver: one long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last, input logic hr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    in_is_hr_char <= hr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_frame(input int foreign_pos);
    for (int i = 0; i < frame.size(); i++)
      send_word(frame[i], i == frame.size() - 1, i != foreign_pos);
  endtask

  // sender pauses until every pending result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // mostly well-formed notifications with random content, some noise and damage
  task automatic build_random_frame();
    logic [7:0] fl;
    logic [15:0] v;
    int n;
    int cut;
    frame.delete();
    foreign_at = -1;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) == 1) foreign_at = $urandom_range(0, n - 1);
    end else begin
      fl = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) fl = fl | FLAG_RR;
      frame.push_back(fl);
      v = ($urandom_range(1) == 1) ? 16'($urandom_range(255)) : 16'($urandom_range(65535));
      frame.push_back(v[7:0]);
      if ((fl & FLAG_RATE16) != 8'd0) frame.push_back(v[15:8]);
      if ((fl & FLAG_ENERGY) != 8'd0) begin
        frame.push_back(8'($urandom_range(255)));
        frame.push_back(8'($urandom_range(255)));
      end
      // now and then more intervals than the cap
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(7))
          0: v = 16'hFFFF;
          1: v = 16'h0000;
          default: v = 16'($urandom_range(65535));
        endcase
        frame.push_back(v[7:0]);
        frame.push_back(v[15:8]);
      end
      if ($urandom_range(9) == 0) frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
      if ($urandom_range(99) < 8) foreign_at = $urandom_range(0, frame.size() - 1);
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // minimal packet, contact not reported
    frame = '{8'h00, 8'h00};
    send_frame(-1);
    // contact detected, top rate, extreme intervals
    frame = '{8'h16, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(-1);
    // 16-bit rate above 255 saturates, contact supported but absent
    frame = '{8'h05, 8'h00, 8'h01};
    send_frame(-1);
    // energy flagged but cut off after its low byte
    frame = '{8'h08, 8'h3C, 8'h12};
    send_frame(-1);
    // too short: flags only, then wide rate missing its high byte
    frame = '{8'h01};
    send_frame(-1);
    frame = '{8'h01, 8'h50};
    send_frame(-1);
    // foreign word on the last byte after one interval
    frame = '{8'h10, 8'h48, 8'h00, 8'h04, 8'hAA};
    send_frame(4);
    // all flags set, energy, one interval and an odd trailing byte
    frame = '{8'hFF, 8'h40, 8'h00, 8'hFF, 8'hFF, 8'h34, 8'h12, 8'h99};
    send_frame(-1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 45; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 45; hold_req <= 1'b1; end
        default: begin idle_pct = 15; stall_pct <= 15; end
      endcase
      if (phase == 0) begin
        // long notification: index saturates and trailing words are ignored
        frame.delete();
        frame.push_back(FLAG_RR);
        for (int i = 0; i < 259; i++) frame.push_back(8'($urandom_range(255)));
        send_frame(-1);
      end
      target = words_sent + RANDOM_ITEMS / 4;
      while (words_sent < target) begin
        build_random_frame();
        send_frame(foreign_at);
      end
      drain();
    end

    stall_pct <= 0;
    while (results_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hrmp_pkg.sv
design/hrmp_parse.sv
design/heart_rate_measurement_parser_core.sv
tb/hrmp_result_checker.sv
tb/heart_rate_measurement_parser_core_tb.sv
